### rtl/core/mep_pkg.sv
// Shared types, widths and constants of the Mandelbrot escape-time pixel block.
package mep_pkg;

  localparam int unsigned MAX_ITER_DEF = 128;
  localparam int unsigned MAX_SIDE_DEF = 4096;

  localparam int unsigned VIEW_W     = 32;
  localparam int unsigned SIDE_REG_W = 13;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned ESC_W      = 7;

  localparam int unsigned SPAN_W  = VIEW_W + 1;
  localparam int unsigned PROD_W  = PIX_W + SPAN_W;
  localparam int unsigned DIV_W   = PROD_W - 1;
  localparam int unsigned MAP_W   = PROD_W + 1;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned A_W       = 31;
  localparam int unsigned PROD2_W   = 2 * A_W;
  localparam int unsigned NW        = 36;

  localparam logic signed [NW-1:0] BIG_POS = NW'(64'sd1073741824);
  localparam logic signed [NW-1:0] BIG_NEG = -BIG_POS;
  localparam logic [PROD2_W-1:0] ESC_BOUND = PROD2_W'(64'd5) << 56;

  localparam logic signed [MAP_W-1:0] MAP_QMAX = MAP_W'(64'sd2147483647);
  localparam logic signed [MAP_W-1:0] MAP_QMIN = MAP_W'(-64'sd2147483648);

  localparam int unsigned SCALE = 126;
  localparam logic [ESC_W-1:0] NO_ESCAPE = 7'd127;

  localparam logic signed [VIEW_W-1:0] X_START_RST = -32'sd536870912;
  localparam logic signed [VIEW_W-1:0] X_END_RST   = 32'sd268435456;
  localparam logic signed [VIEW_W-1:0] Y_START_RST = -32'sd268435456;
  localparam logic signed [VIEW_W-1:0] Y_END_RST   = 32'sd268435456;
  localparam logic [SIDE_REG_W-1:0] SIDE_RST = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_START = 3'd0,
    REG_X_END   = 3'd1,
    REG_Y_START = 3'd2,
    REG_Y_END   = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_HEIGHT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic tag;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [ESC_W-1:0] value;
  } iter_res_t;

endpackage

### rtl/core/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel block: configuration, coordinate map, control.
// The start transfer feeds the x and y products into the divider chain (one cell per quotient
// bit); the mapped point then drives the iteration steps of the shared complex multiply-add.
// The next pixel is taken the cycle after a result.
// Reset restores the default view window and clears all control state; results cannot stall.
module mandelbrot_escape_pixel import mep_pkg::*; #(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEF,
  parameter int unsigned MAX_SIDE       = MAX_SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PIX_W-1:0]     pixel_x_i,
  input  logic [PIX_W-1:0]     pixel_y_i,
  output logic                 done_o,
  output logic [ESC_W-1:0]     escape_value_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VIEW_W-1:0]    cfg_wdata_i
);

  localparam int unsigned DW = $clog2(MAX_SIDE + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED_X,
    S_FEED_Y,
    S_WAIT,
    S_ITER
  } state_e;

  logic signed [VIEW_W-1:0] x_start_q, x_end_q, y_start_q, y_end_q;
  logic [SIDE_REG_W-1:0]    width_q, height_q;

  state_e state_q;
  logic   busy_q;
  logic   go_q;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [DW-1:0]            side_x_q, side_y_q;
  logic signed [VIEW_W-1:0] c_re_q, c_im_q;

  logic signed [SPAN_W-1:0] span_x, span_y;
  logic signed [PROD_W-1:0] prod_sel, prod_neg;
  div_ctl_t                 chain_in, chain_out;
  logic [DIV_W-1:0]         dividend, quotient;
  logic signed [VIEW_W-1:0] lo_sel;
  logic                     neg_sel;
  logic signed [MAP_W-1:0]  qs, qv, mapped;
  logic signed [VIEW_W-1:0] mapped_sat;
  iter_res_t                iter_res;
  logic                     accept;

  function automatic logic [DW-1:0] clamp_side(input logic [SIDE_REG_W-1:0] n);
    logic [DW-1:0] r;
    if (n == '0) begin
      r = DW'(1);
    end else if (32'(n) > 32'(MAX_SIDE)) begin
      r = DW'(MAX_SIDE);
    end else begin
      r = DW'(n);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q <= X_START_RST;
      x_end_q   <= X_END_RST;
      y_start_q <= Y_START_RST;
      y_end_q   <= Y_END_RST;
      width_q   <= SIDE_RST;
      height_q  <= SIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_START: x_start_q <= cfg_wdata_i;
        REG_X_END:   x_end_q   <= cfg_wdata_i;
        REG_Y_START: y_start_q <= cfg_wdata_i;
        REG_Y_END:   y_end_q   <= cfg_wdata_i;
        REG_WIDTH:   width_q   <= cfg_wdata_i[SIDE_REG_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_wdata_i[SIDE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept   = start && !busy_q;
    span_x   = SPAN_W'(x_end_q) - SPAN_W'(x_start_q);
    span_y   = SPAN_W'(y_end_q) - SPAN_W'(y_start_q);

    prod_sel = (state_q == S_FEED_Y) ? prod_y_q : prod_x_q;
    prod_neg = -prod_sel;
    dividend = prod_sel[PROD_W-1] ? prod_neg[DIV_W-1:0] : prod_sel[DIV_W-1:0];
    chain_in.valid = (state_q == S_FEED_X) || (state_q == S_FEED_Y);
    chain_in.tag   = (state_q == S_FEED_Y);

    lo_sel  = chain_out.tag ? y_start_q : x_start_q;
    neg_sel = chain_out.tag ? prod_y_q[PROD_W-1] : prod_x_q[PROD_W-1];
    qs      = $signed({{(MAP_W-DIV_W){1'b0}}, quotient});
    qv      = neg_sel ? -qs : qs;
    mapped  = qv + MAP_W'(lo_sel);
    if (mapped > MAP_QMAX) begin
      mapped_sat = MAP_QMAX[VIEW_W-1:0];
    end else if (mapped < MAP_QMIN) begin
      mapped_sat = MAP_QMIN[VIEW_W-1:0];
    end else begin
      mapped_sat = mapped[VIEW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      go_q    <= 1'b0;
    end else begin
      go_q <= (state_q == S_WAIT) && chain_out.valid && chain_out.tag;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            busy_q  <= 1'b1;
            state_q <= S_FEED_X;
          end
        end
        S_FEED_X: begin
          state_q <= S_FEED_Y;
        end
        S_FEED_Y: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (chain_out.valid && chain_out.tag) begin
            state_q <= S_ITER;
          end
        end
        S_ITER: begin
          if (iter_res.done) begin
            busy_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_x_q <= $signed({1'b0, pixel_x_i}) * span_x;
      prod_y_q <= $signed({1'b0, pixel_y_i}) * span_y;
      side_x_q <= clamp_side(width_q);
      side_y_q <= clamp_side(height_q);
    end
    if (chain_out.valid) begin
      if (chain_out.tag) begin
        c_im_q <= mapped_sat;
      end else begin
        c_re_q <= mapped_sat;
      end
    end
  end

  mep_div_chain #(
    .DW(DW)
  ) u_div_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (chain_in),
    .dividend_i(dividend),
    .side_x_i  (side_x_q),
    .side_y_i  (side_y_q),
    .ctl_o     (chain_out),
    .quotient_o(quotient)
  );

  mep_iter #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (go_q),
    .c_re_i(c_re_q),
    .c_im_i(c_im_q),
    .res_o (iter_res)
  );

  assign busy           = busy_q;
  assign done_o         = iter_res.done;
  assign escape_value_o = iter_res.value;

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q)
    else $error("result transfer while no pixel was in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy did not rise after a start transfer");

  a_chain_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_out.valid |-> (state_q == S_WAIT))
    else $error("divider chain delivered a quotient outside the wait state");
`endif

endmodule

### rtl/core/mep_div_cell.sv
// One restoring division step cell of the coordinate divider chain.
module mep_div_cell import mep_pkg::*; #(
  parameter int unsigned DW = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctl_t         ctl_i,
  input  logic [DW-1:0]    rem_i,
  input  logic [DIV_W-1:0] word_i,
  input  logic [DW-1:0]    side_x_i,
  input  logic [DW-1:0]    side_y_i,
  output div_ctl_t         ctl_o,
  output logic [DW-1:0]    rem_o,
  output logic [DIV_W-1:0] word_o
);

  div_ctl_t         ctl_q;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0] word_q, word_d;
  logic [DW-1:0]    side;
  logic [DW:0]      partial;
  logic             qbit;

  always_comb begin
    side    = ctl_i.tag ? side_y_i : side_x_i;
    partial = {rem_i, word_i[DIV_W-1]};
    if (partial >= {1'b0, side}) begin
      qbit  = 1'b1;
      rem_d = DW'(partial - {1'b0, side});
    end else begin
      qbit  = 1'b0;
      rem_d = partial[DW-1:0];
    end
    word_d = {word_i[DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    word_q <= word_d;
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign word_o = word_q;

endmodule

### rtl/core/mep_div_chain.sv
// Chain of division cells that turns a product magnitude into its quotient by the image side.
module mep_div_chain import mep_pkg::*; #(
  parameter int unsigned DW = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctl_t         ctl_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DW-1:0]    side_x_i,
  input  logic [DW-1:0]    side_y_i,
  output div_ctl_t         ctl_o,
  output logic [DIV_W-1:0] quotient_o
);

  div_ctl_t         ctl_w  [DIV_W+1];
  logic [DW-1:0]    rem_w  [DIV_W+1];
  logic [DIV_W-1:0] word_w [DIV_W+1];

  assign ctl_w[0]  = ctl_i;
  assign rem_w[0]  = '0;
  assign word_w[0] = dividend_i;

  for (genvar k = 0; k < DIV_W; k++) begin : g_cell
    mep_div_cell #(
      .DW(DW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_w[k]),
      .rem_i   (rem_w[k]),
      .word_i  (word_w[k]),
      .side_x_i(side_x_i),
      .side_y_i(side_y_i),
      .ctl_o   (ctl_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .word_o  (word_w[k+1])
    );
  end

  assign ctl_o      = ctl_w[DIV_W];
  assign quotient_o = word_w[DIV_W];

endmodule

### rtl/core/mep_iter.sv
// Escape-time iteration of z = z*z + c with a registered product stage.
module mep_iter import mep_pkg::*; #(
  parameter int unsigned MAX_ITERATIONS = MAX_ITER_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic signed [VIEW_W-1:0] c_re_i,
  input  logic signed [VIEW_W-1:0] c_im_i,
  output iter_res_t                res_o
);

  localparam int unsigned CW     = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned RW     = $clog2(MAX_ITERATIONS);
  localparam int unsigned STEP_Q = SCALE / MAX_ITERATIONS;
  localparam int unsigned STEP_R = SCALE % MAX_ITERATIONS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD
  } state_e;

  state_e     state_q;
  iter_res_t  res_q;
  logic [CW-1:0]    cnt_q;
  logic [ESC_W-1:0] qcur_q, qprev_q;
  logic [RW-1:0]    rem_q;

  logic signed [A_W-1:0]     a_q, b_q;
  logic signed [VIEW_W-1:0]  cre_q, cim_q;
  logic signed [PROD2_W-1:0] aa_q, bb_q, ab_q;

  logic signed [PROD2_W-1:0] sq;
  logic signed [NW-1:0]      sq_sh, cr_sh, nre, nim;
  logic [PROD2_W-1:0]        mag2;
  logic esc_sq, at_end, big, step_on;
  logic [RW:0] r_sum;
  logic        wrap;

  always_comb begin
    sq      = aa_q - bb_q;
    sq_sh   = NW'(sq >>> FRAC_BITS);
    cr_sh   = NW'(ab_q >>> (FRAC_BITS - 1));
    nre     = sq_sh + NW'(cre_q);
    nim     = cr_sh + NW'(cim_q);
    mag2    = $unsigned(aa_q) + $unsigned(bb_q);
    esc_sq  = mag2 > ESC_BOUND;
    at_end  = cnt_q == CW'(MAX_ITERATIONS);
    big     = (nre >= BIG_POS) || (nre <= BIG_NEG) || (nim >= BIG_POS) || (nim <= BIG_NEG);
    step_on = (state_q == S_ADD) && !esc_sq && !at_end && !big;
    r_sum   = {1'b0, rem_q} + (RW+1)'(STEP_R);
    wrap    = r_sum >= (RW+1)'(MAX_ITERATIONS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      cnt_q   <= '0;
      qcur_q  <= '0;
      qprev_q <= '0;
      rem_q   <= '0;
    end else begin
      res_q.done <= (state_q == S_ADD) && (esc_sq || at_end || big);
      case (state_q)
        S_IDLE: begin
          if (go_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
            qcur_q  <= '0;
            qprev_q <= '0;
            rem_q   <= '0;
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (esc_sq) begin
            res_q.value <= qprev_q;
            state_q     <= S_IDLE;
          end else if (at_end) begin
            res_q.value <= NO_ESCAPE;
            state_q     <= S_IDLE;
          end else if (big) begin
            res_q.value <= qcur_q;
            state_q     <= S_IDLE;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            qprev_q <= qcur_q;
            if (wrap) begin
              rem_q  <= RW'(r_sum - (RW+1)'(MAX_ITERATIONS));
              qcur_q <= qcur_q + ESC_W'(STEP_Q + 1);
            end else begin
              rem_q  <= r_sum[RW-1:0];
              qcur_q <= qcur_q + ESC_W'(STEP_Q);
            end
            state_q <= S_MUL;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && go_i) begin
      a_q   <= '0;
      b_q   <= '0;
      cre_q <= c_re_i;
      cim_q <= c_im_i;
    end else if (step_on) begin
      a_q <= nre[A_W-1:0];
      b_q <= nim[A_W-1:0];
    end
    if (state_q == S_MUL) begin
      aa_q <= a_q * a_q;
      bb_q <= b_q * b_q;
      ab_q <= a_q * b_q;
    end
  end

  assign res_o = res_q;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.done |=> !res_q.done)
    else $error("escape result strobe lasted more than one cycle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cnt_q <= CW'(MAX_ITERATIONS)))
    else $error("iteration count ran past its limit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ({1'b0, rem_q} < (RW+1)'(MAX_ITERATIONS)))
    else $error("scaled step remainder out of range");
`endif

endmodule
